@@ rtl/kfpu_pkg.sv @@
// kfpu_pkg: shared types, codes and helpers for the Kalman filter core
`timescale 1ns / 1ps

package kfpu_pkg;

    // default sizes
    localparam int DEF_STATE_DIM = 4;
    localparam int DEF_MEAS_DIM  = 2;
    localparam int DEF_FRAC_BITS = 16;
    localparam int MAX_MEAS      = 2;
    localparam int IDX_W         = 4;

    // item modes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_PREDICT = 2'd1;
    localparam logic [1:0] MODE_UPDATE  = 2'd2;

    // load targets
    localparam logic [2:0] TGT_F = 3'd0;
    localparam logic [2:0] TGT_Q = 3'd1;
    localparam logic [2:0] TGT_H = 3'd2;
    localparam logic [2:0] TGT_R = 3'd3;
    localparam logic [2:0] TGT_X = 3'd4;
    localparam logic [2:0] TGT_P = 3'd5;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    // datapath phases
    localparam logic [3:0] PH_FX  = 4'd0;
    localparam logic [3:0] PH_FP  = 4'd1;
    localparam logic [3:0] PH_FPF = 4'd2;
    localparam logic [3:0] PH_CPX = 4'd3;
    localparam logic [3:0] PH_HX  = 4'd4;
    localparam logic [3:0] PH_PHT = 4'd5;
    localparam logic [3:0] PH_S   = 4'd6;
    localparam logic [3:0] PH_DET = 4'd7;
    localparam logic [3:0] PH_INV = 4'd8;
    localparam logic [3:0] PH_KG  = 4'd9;
    localparam logic [3:0] PH_NXU = 4'd10;
    localparam logic [3:0] PH_IKH = 4'd11;
    localparam logic [3:0] PH_NP  = 4'd12;
    localparam logic [3:0] PH_CPP = 4'd13;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    typedef struct packed {
        logic [1:0]         mode;
        logic [2:0]         target;
        logic [1:0]         row;
        logic [1:0]         col;
        logic signed [31:0] load_value;
        logic signed [31:0] meas_first;
        logic signed [31:0] meas_second;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         elem_index;
        logic signed [31:0] elem_value;
        logic               last;
    } t_out_beat;

    // controller to datapath
    typedef struct packed {
        logic [3:0]       ph;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
        logic             capture;
        logic             init;
        logic             mul;
        logic             write;
        logic             div_start;
        logic             load;
        logic             emit;
        logic [1:0]       emit_status;
        logic             emit_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic div_done;
        logic singular;
    } t_stat;

    // saturate a wide sum to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(S32_MAX)) begin
            r = S32_MAX;
        end else if (v < 64'(S32_MIN)) begin
            r = S32_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/kalman_filter_predict_update_core.sv @@
// kalman_filter_predict_update_core: top level of the fixed-point Kalman filter
//
//  channel  direction  handshake                 beat
//  in       to core    i_in_valid / o_in_stall   kfpu_pkg::t_in_beat
//  out      from core  o_out_valid / i_out_stall kfpu_pkg::t_out_beat
//
//  One item at a time. A load captures the beat, then waits for a free output register
//  and writes the store. Each matrix entry is initialised, sums K products on the single
//  multiply-accumulate unit, drains and is written; a plain copy skips the products.
//  Predict and update emit one beat per state element; the 2x2 inverse is four divisions.
//  Synchronous active-low reset clears the F, Q, H, R and P stores and the state vector.
//  A stalled output holds the core; input is stalled until the last beat is registered.
`timescale 1ns / 1ps

module kalman_filter_predict_update_core #(
    parameter int STATE_DIM = kfpu_pkg::DEF_STATE_DIM,
    parameter int MEAS_DIM  = kfpu_pkg::DEF_MEAS_DIM,
    parameter int FRAC_BITS = kfpu_pkg::DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  kfpu_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output kfpu_pkg::t_out_beat o_out_beat
);

    kfpu_pkg::t_cmd  cmd;
    kfpu_pkg::t_stat stat;

    // sequencer
    kfpu_ctrl #(
        .STATE_DIM (STATE_DIM),
        .MEAS_DIM  (MEAS_DIM)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_beat.mode),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic and storage
    kfpu_dp #(
        .STATE_DIM (STATE_DIM),
        .MEAS_DIM  (MEAS_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_beat  (o_out_beat)
    );

endmodule

@@ rtl/kfpu_div.sv @@
// kfpu_div: restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps

module kfpu_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_d;
    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_nx;

    // one trial subtraction
    always_comb begin
        rem_sh = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_d};
        rem_nx = ge ? (rem_sh - {1'b0, r_d}) : rem_sh;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_d   <= i_den;
        end else if (r_busy) begin
            r_rem <= rem_nx;
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ rtl/kfpu_dp.sv @@
// kfpu_dp: matrix stores, shared multiply-accumulate unit, inverse and output register
`timescale 1ns / 1ps

module kfpu_dp #(
    parameter int STATE_DIM = kfpu_pkg::DEF_STATE_DIM,
    parameter int MEAS_DIM  = kfpu_pkg::DEF_MEAS_DIM,
    parameter int FRAC_BITS = kfpu_pkg::DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kfpu_pkg::t_in_beat  i_in_beat,
    input  kfpu_pkg::t_cmd      i_cmd,
    output kfpu_pkg::t_stat     o_stat,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output kfpu_pkg::t_out_beat o_out_beat
);

    localparam int SD    = STATE_DIM;
    localparam int MM    = kfpu_pkg::MAX_MEAS;
    localparam int IW    = $clog2(SD);
    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int DET_W = 65 - FRAC_BITS;
    localparam logic signed [63:0] HALF  = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    // stores
    logic signed [31:0] r_f   [SD][SD];
    logic signed [31:0] r_qn  [SD][SD];
    logic signed [31:0] r_h   [MM][SD];
    logic signed [31:0] r_r   [MM][MM];
    logic signed [31:0] r_x   [SD];
    logic signed [31:0] r_pc  [SD][SD];
    // intermediates
    logic signed [31:0] r_nx  [SD];
    logic signed [31:0] r_ta  [SD][SD];
    logic signed [31:0] r_tb  [SD][SD];
    logic signed [31:0] r_y   [MM];
    logic signed [31:0] r_pht [SD][MM];
    logic signed [31:0] r_s   [MM][MM];
    logic signed [31:0] r_inv [MM][MM];
    logic signed [31:0] r_kg  [SD][MM];
    logic signed [DET_W-1:0] r_det;

    kfpu_pkg::t_in_beat r_in;
    logic signed [63:0] r_p;
    logic               r_pv;
    logic               r_pneg;
    logic signed [63:0] r_acc;
    logic               r_qneg;
    logic               r_ov;
    kfpu_pkg::t_out_beat r_out;

    logic [IW-1:0]      ii, jj, kk;
    logic               mi, mj, mk;
    logic signed [31:0] a_op, b_op, bias;
    logic               sub, pneg;
    logic signed [63:0] rp;
    logic signed [31:0] wr_val;
    logic               load_ok;
    logic               out_free;

    // divider operands
    logic signed [31:0] s_sel;
    logic               adj_neg;
    logic [31:0]        abs_s;
    logic [NUM_W-1:0]   num_mag;
    logic               num_neg;
    logic signed [DET_W-1:0] den_src;
    logic [DET_W-1:0]   den_mag;
    logic               div_done;
    logic [NUM_W-1:0]   quot;
    logic signed [31:0] qsat;

    assign ii = i_cmd.i[IW-1:0];
    assign jj = i_cmd.j[IW-1:0];
    assign kk = i_cmd.k[IW-1:0];
    assign mi = i_cmd.i[0];
    assign mj = i_cmd.j[0];
    assign mk = i_cmd.k[0];

    // operand selection per phase
    always_comb begin
        a_op = '0;
        b_op = '0;
        bias = '0;
        sub  = 1'b0;
        pneg = 1'b0;
        unique case (i_cmd.ph)
            kfpu_pkg::PH_FX: begin
                a_op = r_f[ii][kk];
                b_op = r_x[kk];
            end
            kfpu_pkg::PH_FP: begin
                a_op = r_f[ii][kk];
                b_op = r_pc[kk][jj];
            end
            kfpu_pkg::PH_FPF: begin
                a_op = r_ta[ii][kk];
                b_op = r_f[jj][kk];
                bias = r_qn[ii][jj];
            end
            kfpu_pkg::PH_CPX: begin
                bias = r_nx[ii];
            end
            kfpu_pkg::PH_HX: begin
                a_op = r_h[mi][kk];
                b_op = r_x[kk];
                bias = mi ? r_in.meas_second : r_in.meas_first;
                sub  = 1'b1;
            end
            kfpu_pkg::PH_PHT: begin
                a_op = r_pc[ii][kk];
                b_op = r_h[mj][kk];
            end
            kfpu_pkg::PH_S: begin
                a_op = r_h[mi][kk];
                b_op = r_pht[kk][mj];
                bias = r_r[mi][mj];
            end
            kfpu_pkg::PH_DET: begin
                a_op = mk ? r_s[0][1] : r_s[0][0];
                b_op = mk ? r_s[1][0] : r_s[1][1];
                pneg = mk;
            end
            kfpu_pkg::PH_KG: begin
                a_op = r_pht[ii][mk];
                b_op = r_inv[mk][mj];
            end
            kfpu_pkg::PH_NXU: begin
                a_op = r_kg[ii][mk];
                b_op = r_y[mk];
                bias = r_x[ii];
            end
            kfpu_pkg::PH_IKH: begin
                a_op = r_kg[ii][mk];
                b_op = r_h[mk][jj];
                bias = (ii == jj) ? ONE_Q : 32'sd0;
                sub  = 1'b1;
            end
            kfpu_pkg::PH_NP: begin
                a_op = r_ta[ii][kk];
                b_op = r_pc[kk][jj];
            end
            kfpu_pkg::PH_CPP: begin
                bias = r_tb[ii][jj];
            end
            default: begin
                a_op = '0;
            end
        endcase
    end

    // multiply, then round and accumulate
    assign rp = (r_p + HALF) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.mul;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= 64'(a_op) * 64'(b_op);
        r_pneg <= pneg;
        if (i_cmd.init) begin
            r_acc <= sub ? 64'sd0 : 64'(bias);
        end else if (r_pv) begin
            r_acc <= r_pneg ? (r_acc - rp) : (r_acc + rp);
        end
    end

    assign wr_val = sub ? kfpu_pkg::sat32(64'(bias) - 64'(kfpu_pkg::sat32(r_acc)))
                        : kfpu_pkg::sat32(r_acc);

    // load range check
    always_comb begin
        unique case (r_in.target)
            kfpu_pkg::TGT_F, kfpu_pkg::TGT_Q, kfpu_pkg::TGT_P:
                load_ok = (int'(r_in.row) < SD) && (int'(r_in.col) < SD);
            kfpu_pkg::TGT_H:
                load_ok = (int'(r_in.row) < MEAS_DIM) && (int'(r_in.col) < SD);
            kfpu_pkg::TGT_R:
                load_ok = (int'(r_in.row) < MEAS_DIM) && (int'(r_in.col) < MEAS_DIM);
            kfpu_pkg::TGT_X:
                load_ok = (int'(r_in.row) < SD) && (r_in.col == 2'd0);
            default:
                load_ok = 1'b0;
        endcase
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in <= i_in_beat;
        end
    end

    // architectural stores, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < SD; r++) begin
                r_x[r] <= '0;
                for (int c = 0; c < SD; c++) begin
                    r_f[r][c]  <= '0;
                    r_qn[r][c] <= '0;
                    r_pc[r][c] <= '0;
                end
            end
            for (int r = 0; r < MM; r++) begin
                for (int c = 0; c < SD; c++) begin
                    r_h[r][c] <= '0;
                end
                for (int c = 0; c < MM; c++) begin
                    r_r[r][c] <= '0;
                end
            end
        end else begin
            if (i_cmd.load && load_ok) begin
                unique case (r_in.target)
                    kfpu_pkg::TGT_F: r_f[IW'(r_in.row)][IW'(r_in.col)]  <= r_in.load_value;
                    kfpu_pkg::TGT_Q: r_qn[IW'(r_in.row)][IW'(r_in.col)] <= r_in.load_value;
                    kfpu_pkg::TGT_H: r_h[r_in.row[0]][IW'(r_in.col)]    <= r_in.load_value;
                    kfpu_pkg::TGT_R: r_r[r_in.row[0]][r_in.col[0]]      <= r_in.load_value;
                    kfpu_pkg::TGT_X: r_x[IW'(r_in.row)]                 <= r_in.load_value;
                    kfpu_pkg::TGT_P: r_pc[IW'(r_in.row)][IW'(r_in.col)] <= r_in.load_value;
                    default: r_x[0] <= r_x[0];
                endcase
            end
            if (i_cmd.write) begin
                if (i_cmd.ph == kfpu_pkg::PH_FPF || i_cmd.ph == kfpu_pkg::PH_CPP) begin
                    r_pc[ii][jj] <= wr_val;
                end
                if (i_cmd.ph == kfpu_pkg::PH_CPX) begin
                    r_x[ii] <= wr_val;
                end
            end
        end
    end

    // intermediate results
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            unique case (i_cmd.ph)
                kfpu_pkg::PH_FX, kfpu_pkg::PH_NXU: r_nx[ii]     <= wr_val;
                kfpu_pkg::PH_FP, kfpu_pkg::PH_IKH: r_ta[ii][jj] <= wr_val;
                kfpu_pkg::PH_NP:                   r_tb[ii][jj] <= wr_val;
                kfpu_pkg::PH_HX:                   r_y[mi]      <= wr_val;
                kfpu_pkg::PH_PHT:                  r_pht[ii][mj] <= wr_val;
                kfpu_pkg::PH_S:                    r_s[mi][mj]  <= wr_val;
                kfpu_pkg::PH_DET:                  r_det        <= r_acc[DET_W-1:0];
                kfpu_pkg::PH_INV:                  r_inv[mi][mj] <= qsat;
                kfpu_pkg::PH_KG:                   r_kg[ii][mj] <= wr_val;
                default:                           r_det        <= r_det;
            endcase
        end
    end

    // adjugate numerator and determinant for the 2x2 inverse, or one over S when MEAS_DIM is 1
    always_comb begin
        unique case ({mi, mj})
            2'b00:   begin s_sel = r_s[1][1]; adj_neg = 1'b0; end
            2'b01:   begin s_sel = r_s[0][1]; adj_neg = 1'b1; end
            2'b10:   begin s_sel = r_s[1][0]; adj_neg = 1'b1; end
            default: begin s_sel = r_s[0][0]; adj_neg = 1'b0; end
        endcase
        abs_s = s_sel[31] ? 32'(-s_sel) : 32'(s_sel);
        if (MEAS_DIM == 2) begin
            num_mag = {abs_s, {FRAC_BITS{1'b0}}};
            num_neg = s_sel[31] ^ adj_neg;
            den_src = r_det;
        end else begin
            num_mag = NUM_W'(1) << (2 * FRAC_BITS);
            num_neg = 1'b0;
            den_src = DET_W'(r_s[0][0]);
        end
        den_mag = den_src[DET_W-1] ? DET_W'(-den_src) : DET_W'(den_src);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_qneg <= num_neg ^ den_src[DET_W-1];
        end
    end

    kfpu_div #(
        .NUM_W (NUM_W),
        .DEN_W (DET_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (num_mag),
        .i_den   (den_mag),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // signed quotient with saturation
    always_comb begin
        if (!r_qneg) begin
            qsat = (|quot[NUM_W-1:31]) ? kfpu_pkg::S32_MAX : $signed({1'b0, quot[30:0]});
        end else if ((|quot[NUM_W-1:32]) || (quot[31] && (|quot[30:0]))) begin
            qsat = kfpu_pkg::S32_MIN;
        end else begin
            qsat = $signed(32'(-quot[31:0]));
        end
    end

    // output register
    assign out_free = !r_ov || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load || i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.status     <= load_ok ? kfpu_pkg::ST_OK : kfpu_pkg::ST_RANGE;
            r_out.elem_index <= 2'd0;
            r_out.elem_value <= '0;
            r_out.last       <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out.status     <= i_cmd.emit_status;
            r_out.elem_index <= i_cmd.i[1:0];
            r_out.elem_value <= r_x[ii];
            r_out.last       <= i_cmd.emit_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_beat  = r_out;

    assign o_stat.out_free = out_free;
    assign o_stat.div_done = div_done;
    assign o_stat.singular = (MEAS_DIM == 2) ? (r_det == '0) : (r_s[0][0] == 32'sd0);

endmodule

@@ rtl/kfpu_ctrl.sv @@
// kfpu_ctrl: sequencer that walks the predict and update phases element by element
`timescale 1ns / 1ps

module kfpu_ctrl #(
    parameter int STATE_DIM = kfpu_pkg::DEF_STATE_DIM,
    parameter int MEAS_DIM  = kfpu_pkg::DEF_MEAS_DIM
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_in_mode,
    output logic            o_in_stall,
    input  kfpu_pkg::t_stat i_stat,
    output kfpu_pkg::t_cmd  o_cmd
);

    localparam int IX = kfpu_pkg::IDX_W;
    localparam logic [IX-1:0] SD_N = IX'(STATE_DIM);
    localparam logic [IX-1:0] MD_N = IX'(MEAS_DIM);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_INIT  = 4'd2;
    localparam logic [3:0] S_MUL   = 4'd3;
    localparam logic [3:0] S_DRAIN = 4'd4;
    localparam logic [3:0] S_WR    = 4'd5;
    localparam logic [3:0] S_CHECK = 4'd6;
    localparam logic [3:0] S_DIVS  = 4'd7;
    localparam logic [3:0] S_DIVW  = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [3:0]    r_ph, n_ph;
    logic [IX-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic [1:0]    r_st, n_st;
    logic [IX-1:0] in_n, jn_n, kn_n;
    logic [3:0]    ph_next;
    logic          elem_done;

    // loop bounds of each phase
    always_comb begin
        unique case (r_ph)
            kfpu_pkg::PH_FX:  begin in_n = SD_N;  jn_n = IX'(1); kn_n = SD_N;  end
            kfpu_pkg::PH_FP:  begin in_n = SD_N;  jn_n = SD_N;   kn_n = SD_N;  end
            kfpu_pkg::PH_FPF: begin in_n = SD_N;  jn_n = SD_N;   kn_n = SD_N;  end
            kfpu_pkg::PH_CPX: begin in_n = SD_N;  jn_n = IX'(1); kn_n = '0;    end
            kfpu_pkg::PH_HX:  begin in_n = MD_N;  jn_n = IX'(1); kn_n = SD_N;  end
            kfpu_pkg::PH_PHT: begin in_n = SD_N;  jn_n = MD_N;   kn_n = SD_N;  end
            kfpu_pkg::PH_S:   begin in_n = MD_N;  jn_n = MD_N;   kn_n = SD_N;  end
            kfpu_pkg::PH_DET: begin in_n = IX'(1); jn_n = IX'(1); kn_n = IX'(2); end
            kfpu_pkg::PH_INV: begin in_n = MD_N;  jn_n = MD_N;   kn_n = '0;    end
            kfpu_pkg::PH_KG:  begin in_n = SD_N;  jn_n = MD_N;   kn_n = MD_N;  end
            kfpu_pkg::PH_NXU: begin in_n = SD_N;  jn_n = IX'(1); kn_n = MD_N;  end
            kfpu_pkg::PH_IKH: begin in_n = SD_N;  jn_n = SD_N;   kn_n = MD_N;  end
            kfpu_pkg::PH_NP:  begin in_n = SD_N;  jn_n = SD_N;   kn_n = SD_N;  end
            default:          begin in_n = SD_N;  jn_n = SD_N;   kn_n = '0;    end
        endcase
    end

    // phase order
    always_comb begin
        unique case (r_ph)
            kfpu_pkg::PH_FX:  ph_next = kfpu_pkg::PH_FP;
            kfpu_pkg::PH_FP:  ph_next = kfpu_pkg::PH_FPF;
            kfpu_pkg::PH_HX:  ph_next = kfpu_pkg::PH_PHT;
            kfpu_pkg::PH_PHT: ph_next = kfpu_pkg::PH_S;
            kfpu_pkg::PH_S:   ph_next = kfpu_pkg::PH_DET;
            kfpu_pkg::PH_INV: ph_next = kfpu_pkg::PH_KG;
            kfpu_pkg::PH_KG:  ph_next = kfpu_pkg::PH_NXU;
            kfpu_pkg::PH_NXU: ph_next = kfpu_pkg::PH_IKH;
            kfpu_pkg::PH_IKH: ph_next = kfpu_pkg::PH_NP;
            kfpu_pkg::PH_NP:  ph_next = kfpu_pkg::PH_CPP;
            default:          ph_next = kfpu_pkg::PH_CPX;
        endcase
    end

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_ph      = r_ph;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_st      = r_st;
        elem_done = 1'b0;
        o_cmd             = '0;
        o_cmd.ph          = r_ph;
        o_cmd.i           = r_i;
        o_cmd.j           = r_j;
        o_cmd.k           = r_k;
        o_cmd.emit_status = r_st;
        o_cmd.emit_last   = (r_i == SD_N - IX'(1));

        unique case (r_state)
            S_IDLE: begin
                n_i  = '0;
                n_j  = '0;
                n_st = kfpu_pkg::ST_OK;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_in_mode)
                        kfpu_pkg::MODE_LOAD: begin
                            n_state = S_LOAD;
                        end
                        kfpu_pkg::MODE_PREDICT: begin
                            n_ph    = kfpu_pkg::PH_FX;
                            n_state = S_INIT;
                        end
                        kfpu_pkg::MODE_UPDATE: begin
                            n_ph    = kfpu_pkg::PH_HX;
                            n_state = S_INIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_k        = '0;
                n_state    = (kn_n == '0) ? S_WR : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_k       = r_k + IX'(1);
                if (r_k == kn_n - IX'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.write = 1'b1;
                elem_done   = 1'b1;
            end
            S_CHECK: begin
                n_i = '0;
                n_j = '0;
                if (i_stat.singular) begin
                    n_st    = kfpu_pkg::ST_SINGULAR;
                    n_state = S_EMIT;
                end else begin
                    n_ph    = kfpu_pkg::PH_INV;
                    n_state = S_DIVS;
                end
            end
            S_DIVS: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                if (i_stat.div_done) begin
                    o_cmd.write = 1'b1;
                    elem_done   = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_i        = r_i + IX'(1);
                    if (r_i == SD_N - IX'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // step to the next element, then to the next phase
        if (elem_done) begin
            if (r_j + IX'(1) != jn_n) begin
                n_j     = r_j + IX'(1);
                n_state = (r_ph == kfpu_pkg::PH_INV) ? S_DIVS : S_INIT;
            end else if (r_i + IX'(1) != in_n) begin
                n_j     = '0;
                n_i     = r_i + IX'(1);
                n_state = (r_ph == kfpu_pkg::PH_INV) ? S_DIVS : S_INIT;
            end else begin
                n_i = '0;
                n_j = '0;
                if (r_ph == kfpu_pkg::PH_CPX) begin
                    n_state = S_EMIT;
                end else if (r_ph == kfpu_pkg::PH_DET ||
                             (r_ph == kfpu_pkg::PH_S && MEAS_DIM == 1)) begin
                    n_state = S_CHECK;
                end else begin
                    n_ph    = ph_next;
                    n_state = S_INIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= kfpu_pkg::PH_FX;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_st    <= kfpu_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_st    <= n_st;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
